// File: rtl/least_squares_line_fit_macros.svh
// ----------------------------------------------------------------------------
// least_squares_line_fit_macros.svh
// Assertion helpers shared by the line fit RTL.
// ----------------------------------------------------------------------------
`ifndef LEAST_SQUARES_LINE_FIT_MACROS_SVH
`define LEAST_SQUARES_LINE_FIT_MACROS_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define LSF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk_i, off during reset
`define LSF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/lsf_pkg.sv
// ----------------------------------------------------------------------------
// lsf_pkg
// Shared constants, step codes and control structs of the line fit block.
// ----------------------------------------------------------------------------
package lsf_pkg;

  localparam int DefMaxSamples = 1024;
  localparam int DefSampleBits = 16;

  localparam int StepW = 5;

  // datapath operation steps, run in this order after the summing pass
  localparam logic [StepW-1:0] STEP_N_SXX   = 5'd0;
  localparam logic [StepW-1:0] STEP_SX_SX   = 5'd1;
  localparam logic [StepW-1:0] STEP_N_SXY   = 5'd2;
  localparam logic [StepW-1:0] STEP_SX_SY   = 5'd3;
  localparam logic [StepW-1:0] STEP_N_SYY   = 5'd4;
  localparam logic [StepW-1:0] STEP_SY_SY   = 5'd5;
  localparam logic [StepW-1:0] STEP_SLOPE   = 5'd6;
  localparam logic [StepW-1:0] STEP_SY_DXX  = 5'd7;
  localparam logic [StepW-1:0] STEP_SX_DXY  = 5'd8;
  localparam logic [StepW-1:0] STEP_N_DXX   = 5'd9;
  localparam logic [StepW-1:0] STEP_ICPT    = 5'd10;
  localparam logic [StepW-1:0] STEP_AXY_SQ  = 5'd11;
  localparam logic [StepW-1:0] STEP_DXX_DYY = 5'd12;
  localparam logic [StepW-1:0] STEP_R2      = 5'd13;
  localparam logic [StepW-1:0] STEP_SE_DEN  = 5'd14;
  localparam logic [StepW-1:0] STEP_SE_DIV  = 5'd15;
  localparam logic [StepW-1:0] STEP_SQRT    = 5'd16;
  localparam logic [StepW-1:0] STEP_FINAL   = STEP_SQRT;

  // fit status codes
  localparam logic [1:0] FIT_OK      = 2'd0;
  localparam logic [1:0] FIT_ZERO_VX = 2'd1;
  localparam logic [1:0] FIT_ZERO_VY = 2'd2;
  localparam logic [1:0] FIT_FEW    = 2'd3;

  localparam logic [1:0] OrderReset = 2'd2;

  typedef struct packed {
    logic             store;       // write accepted word to the store
    logic             pass_start;  // begin summing pass over the store
    logic             op_start;    // launch the current step
    logic [StepW-1:0] step;        // current step code
    logic             load;        // move fit into output register
  } lsf_cmd_t;

  typedef struct packed {
    logic pass_done;
    logic op_done;
  } lsf_stat_t;

endpackage

// File: rtl/lsf_ram.sv
// ----------------------------------------------------------------------------
// lsf_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module lsf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: rtl/lsf_datapath.sv
// ----------------------------------------------------------------------------
// lsf_datapath
// Sample store, summing pass and shared serial multiply, divide and root.
// ----------------------------------------------------------------------------
module lsf_datapath #(
  parameter int MAX_SAMPLES = lsf_pkg::DefMaxSamples,
  parameter int SAMPLE_BITS = lsf_pkg::DefSampleBits
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  lsf_pkg::lsf_cmd_t                    cmd_i,
  output lsf_pkg::lsf_stat_t                   stat_o,
  input  logic signed [SAMPLE_BITS-1:0]        sample_x_i,
  input  logic signed [SAMPLE_BITS-1:0]        sample_y_i,
  input  logic                                 cfg_we_i,
  input  logic [1:0]                           cfg_wdata_i,
  output logic signed [31:0]                   slope_o,
  output logic signed [47:0]                   intercept_o,
  output logic [16:0]                          r_squared_o,
  output logic [31:0]                          std_error_o,
  output logic [$clog2(MAX_SAMPLES+1)-1:0]     sample_count_o,
  output logic [1:0]                           fit_status_o
);

  import lsf_pkg::*;

  localparam int CntW  = $clog2(MAX_SAMPLES + 1);
  localparam int AddrW = $clog2(MAX_SAMPLES);
  localparam int ProdW = 2 * SAMPLE_BITS;
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_SAMPLES);
  localparam logic [7:0] DivLastK17 = 8'(128 + 17 - 1);
  localparam logic [7:0] DivLastK32 = 8'(128 + 32 - 1);
  localparam logic [63:0] LimSlopeP = 64'h7FFF_FFFF;
  localparam logic [63:0] LimSlopeN = 64'h8000_0000;
  localparam logic [63:0] LimIcptP  = 64'h7FFF_FFFF_FFFF;
  localparam logic [63:0] LimIcptN  = 64'h8000_0000_0000;
  localparam logic [63:0] LimR2     = 64'h1_0000;

  function automatic logic [63:0] mag64(input logic [63:0] v);
    return v[63] ? (64'd0 - v) : v;
  endfunction

  // halve with rounding, clamp, apply sign
  function automatic logic [63:0] round_q16(input logic [63:0] q, input logic ovf,
                                            input logic neg, input logic [63:0] lim);
    logic [63:0] v;
    v = {1'b0, q[63:1]} + {63'd0, q[0]};
    if (ovf || (v > lim)) v = lim;
    return neg ? (64'd0 - v) : v;
  endfunction

  // --------------------------------------------------------------------------
  // config register
  logic [1:0] order_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= OrderReset;
    end else if (cfg_we_i) begin
      order_q <= cfg_wdata_i;
    end
  end

  // --------------------------------------------------------------------------
  // sample store
  logic [CntW-1:0] count_q;
  logic            wr_en;
  logic [CntW-1:0] rd_cnt_q;
  logic [SAMPLE_BITS-1:0] x_rd, y_rd;

  assign wr_en = cmd_i.store && (count_q < MaxCnt);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.load) begin
      count_q <= '0;
    end else if (wr_en) begin
      count_q <= count_q + CntW'(1);
    end
  end

  lsf_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_SAMPLES)) u_x_ram (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(count_q[AddrW-1:0]),
    .wdata_i(sample_x_i),
    .raddr_i(rd_cnt_q[AddrW-1:0]),
    .rdata_o(x_rd)
  );

  lsf_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_SAMPLES)) u_y_ram (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(count_q[AddrW-1:0]),
    .wdata_i(sample_y_i),
    .raddr_i(rd_cnt_q[AddrW-1:0]),
    .rdata_o(y_rd)
  );

  // --------------------------------------------------------------------------
  // summing pass: address, read, products, accumulate
  logic rd_act_q, v1_q, v2_q;
  logic [63:0] xe_q, ye_q, pxx_q, pxy_q, pyy_q;
  logic [63:0] sx_q, sy_q, sxx_q, sxy_q, syy_q;
  logic signed [ProdW-1:0] pxx, pxy, pyy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_act_q <= 1'b0;
      rd_cnt_q <= '0;
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
    end else begin
      v1_q <= rd_act_q;
      v2_q <= v1_q;
      if (cmd_i.pass_start) begin
        rd_cnt_q <= '0;
        rd_act_q <= 1'b1;
      end else if (rd_act_q) begin
        rd_cnt_q <= rd_cnt_q + CntW'(1);
        if (rd_cnt_q + CntW'(1) == count_q) rd_act_q <= 1'b0;
      end
    end
  end

  assign pxx = $signed(x_rd) * $signed(x_rd);
  assign pxy = $signed(x_rd) * $signed(y_rd);
  assign pyy = $signed(y_rd) * $signed(y_rd);

  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      xe_q  <= 64'($signed(x_rd));
      ye_q  <= 64'($signed(y_rd));
      pxx_q <= 64'(pxx);
      pxy_q <= 64'(pxy);
      pyy_q <= 64'(pyy);
    end
    if (cmd_i.pass_start) begin
      sx_q  <= '0;
      sy_q  <= '0;
      sxx_q <= '0;
      sxy_q <= '0;
      syy_q <= '0;
    end else if (v2_q) begin
      sx_q  <= sx_q + xe_q;
      sy_q  <= sy_q + ye_q;
      sxx_q <= sxx_q + pxx_q;
      sxy_q <= sxy_q + pxy_q;
      syy_q <= syy_q + pyy_q;
    end
  end

  // --------------------------------------------------------------------------
  // fit registers and operand selection
  logic [63:0]  n64, dof, adxy;
  logic [63:0]  dxx_q, dxy_q, dyy_q;
  logic [127:0] t_q, inum_q, iden_q, p2_q, dd_q;
  logic [63:0]  slope_q, icpt_q, r2_q, sq_in_q;
  logic         se_sat_q;
  logic         dxx_nz, dyy_nz;

  assign n64    = 64'(count_q);
  assign dof    = n64 - {62'd0, order_q};
  assign adxy   = mag64(dxy_q);
  assign dxx_nz = (dxx_q != 64'd0);
  assign dyy_nz = (dyy_q != 64'd0);

  logic         sel_mul, sel_div, sel_sqrt;
  logic [127:0] m_a;
  logic [63:0]  m_b;
  logic         m_neg;
  logic [127:0] d_num, d_den;
  logic [7:0]   d_last;

  always_comb begin
    sel_mul  = 1'b0;
    sel_div  = 1'b0;
    sel_sqrt = 1'b0;
    m_a      = '0;
    m_b      = '0;
    m_neg    = 1'b0;
    d_num    = '0;
    d_den    = '0;
    d_last   = DivLastK17;
    unique case (cmd_i.step)
      STEP_N_SXX:   begin sel_mul = 1'b1; m_a = {64'd0, n64};  m_b = sxx_q; end
      STEP_SX_SX:   begin sel_mul = 1'b1; m_a = {64'd0, sx_q}; m_b = sx_q;  end
      STEP_N_SXY:   begin sel_mul = 1'b1; m_a = {64'd0, n64};  m_b = sxy_q; end
      STEP_SX_SY:   begin sel_mul = 1'b1; m_a = {64'd0, sx_q}; m_b = sy_q;  end
      STEP_N_SYY:   begin sel_mul = 1'b1; m_a = {64'd0, n64};  m_b = syy_q; end
      STEP_SY_SY:   begin sel_mul = 1'b1; m_a = {64'd0, sy_q}; m_b = sy_q;  end
      STEP_SLOPE: begin
        sel_div = 1'b1;
        d_num   = {64'd0, adxy};
        d_den   = {64'd0, dxx_q};
      end
      STEP_SY_DXX: begin
        sel_mul = 1'b1;
        m_a     = {64'd0, mag64(sy_q)};
        m_b     = mag64(dxx_q);
        m_neg   = sy_q[63] ^ dxx_q[63];
      end
      STEP_SX_DXY: begin
        sel_mul = 1'b1;
        m_a     = {64'd0, mag64(sx_q)};
        m_b     = adxy;
        m_neg   = sx_q[63] ^ dxy_q[63];
      end
      STEP_N_DXX:   begin sel_mul = 1'b1; m_a = {64'd0, n64};   m_b = dxx_q; end
      STEP_ICPT: begin
        sel_div = 1'b1;
        d_num   = inum_q[127] ? (128'd0 - inum_q) : inum_q;
        d_den   = iden_q;
      end
      STEP_AXY_SQ:  begin sel_mul = 1'b1; m_a = {64'd0, adxy};  m_b = adxy;  end
      STEP_DXX_DYY: begin sel_mul = 1'b1; m_a = {64'd0, dxx_q}; m_b = dyy_q; end
      STEP_R2:      begin sel_div = 1'b1; d_num = p2_q; d_den = dd_q; end
      // iden already holds n when x variance is zero
      STEP_SE_DEN:  begin sel_mul = 1'b1; m_a = iden_q; m_b = dof; end
      STEP_SE_DIV: begin
        sel_div = 1'b1;
        d_num   = dxx_nz ? (dd_q - p2_q) : {64'd0, dyy_q};
        d_den   = t_q;
        d_last  = DivLastK32;
      end
      STEP_SQRT:    sel_sqrt = 1'b1;
      default:      ;
    endcase
  end

  // --------------------------------------------------------------------------
  // shift-add multiplier, 128 x 64 bits mod 2^128, one bit a cycle
  logic         mul_busy_q, mul_done_q, mul_neg_q;
  logic [5:0]   mul_cnt_q;
  logic [127:0] ma_q, mp_q, mul_res;
  logic [63:0]  mb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_busy_q <= 1'b0;
      mul_done_q <= 1'b0;
      mul_cnt_q  <= '0;
    end else begin
      mul_done_q <= 1'b0;
      if (cmd_i.op_start && sel_mul) begin
        mul_busy_q <= 1'b1;
        mul_cnt_q  <= '0;
      end else if (mul_busy_q) begin
        mul_cnt_q <= mul_cnt_q + 6'd1;
        if (mul_cnt_q == 6'd63) begin
          mul_busy_q <= 1'b0;
          mul_done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op_start && sel_mul) begin
      ma_q      <= m_a;
      mb_q      <= m_b;
      mp_q      <= '0;
      mul_neg_q <= m_neg;
    end else if (mul_busy_q) begin
      if (mb_q[0]) mp_q <= mp_q + ma_q;
      ma_q <= {ma_q[126:0], 1'b0};
      mb_q <= {1'b0, mb_q[63:1]};
    end
  end

  assign mul_res = mul_neg_q ? (128'd0 - mp_q) : mp_q;

  // --------------------------------------------------------------------------
  // restoring divider, one quotient bit a cycle, sticky overflow past 64 bits
  logic         div_busy_q, div_done_q, div_ovf_q;
  logic [7:0]   div_cnt_q, div_last_q;
  logic [127:0] num_sh_q, rem_q, den_q, rem_sh;
  logic [63:0]  quo_q;
  logic         div_ge;

  assign rem_sh = {rem_q[126:0], num_sh_q[127]};
  assign div_ge = (rem_sh >= den_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_busy_q <= 1'b0;
      div_done_q <= 1'b0;
      div_cnt_q  <= '0;
    end else begin
      div_done_q <= 1'b0;
      if (cmd_i.op_start && sel_div) begin
        div_busy_q <= 1'b1;
        div_cnt_q  <= '0;
      end else if (div_busy_q) begin
        div_cnt_q <= div_cnt_q + 8'd1;
        if (div_cnt_q == div_last_q) begin
          div_busy_q <= 1'b0;
          div_done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op_start && sel_div) begin
      num_sh_q   <= d_num;
      den_q      <= d_den;
      div_last_q <= d_last;
      rem_q      <= '0;
      quo_q      <= '0;
      div_ovf_q  <= 1'b0;
    end else if (div_busy_q) begin
      num_sh_q  <= {num_sh_q[126:0], 1'b0};
      rem_q     <= div_ge ? (rem_sh - den_q) : rem_sh;
      div_ovf_q <= div_ovf_q | quo_q[63];
      quo_q     <= {quo_q[62:0], div_ge};
    end
  end

  // --------------------------------------------------------------------------
  // integer square root, one result bit a cycle
  logic        sq_busy_q, sq_done_q;
  logic [4:0]  sq_cnt_q;
  logic [63:0] sq_v_q, sq_res_q, sq_bit_q, sq_sum;

  assign sq_sum = sq_res_q + sq_bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_busy_q <= 1'b0;
      sq_done_q <= 1'b0;
      sq_cnt_q  <= '0;
    end else begin
      sq_done_q <= 1'b0;
      if (cmd_i.op_start && sel_sqrt) begin
        sq_busy_q <= 1'b1;
        sq_cnt_q  <= '0;
      end else if (sq_busy_q) begin
        sq_cnt_q <= sq_cnt_q + 5'd1;
        if (sq_cnt_q == 5'd31) begin
          sq_busy_q <= 1'b0;
          sq_done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op_start && sel_sqrt) begin
      sq_v_q   <= sq_in_q;
      sq_res_q <= '0;
      sq_bit_q <= 64'd1 << 62;
    end else if (sq_busy_q) begin
      if (sq_v_q >= sq_sum) begin
        sq_v_q   <= sq_v_q - sq_sum;
        sq_res_q <= {1'b0, sq_res_q[63:1]} + sq_bit_q;
      end else begin
        sq_res_q <= {1'b0, sq_res_q[63:1]};
      end
      sq_bit_q <= {2'b00, sq_bit_q[63:2]};
    end
  end

  assign stat_o.op_done   = mul_done_q | div_done_q | sq_done_q;
  assign stat_o.pass_done = v2_q & ~v1_q & ~rd_act_q;

  // --------------------------------------------------------------------------
  // write back of finished step
  always_ff @(posedge clk_i) begin
    if (mul_done_q) begin
      case (cmd_i.step)
        STEP_SX_SX:   dxx_q  <= t_q[63:0] - mul_res[63:0];
        STEP_SX_SY:   dxy_q  <= t_q[63:0] - mul_res[63:0];
        STEP_SY_SY:   dyy_q  <= t_q[63:0] - mul_res[63:0];
        STEP_SX_DXY:  inum_q <= mul_neg_q ? (t_q + mp_q) : (t_q - mp_q);
        STEP_N_DXX: begin
          // zero x variance: intercept falls back to the mean of y
          iden_q <= dxx_nz ? mul_res : {64'd0, n64};
          if (!dxx_nz) inum_q <= {{64{sy_q[63]}}, sy_q};
        end
        STEP_AXY_SQ:  p2_q <= mul_res;
        STEP_DXX_DYY: dd_q <= mul_res;
        default:      t_q  <= mul_res;
      endcase
    end
    if (div_done_q) begin
      case (cmd_i.step)
        STEP_SLOPE:
          slope_q <= dxx_nz ? round_q16(quo_q, div_ovf_q, dxy_q[63],
                                        dxy_q[63] ? LimSlopeN : LimSlopeP) : 64'd0;
        STEP_ICPT:
          icpt_q <= round_q16(quo_q, div_ovf_q, inum_q[127],
                              inum_q[127] ? LimIcptN : LimIcptP);
        STEP_R2:
          r2_q <= (dxx_nz && dyy_nz) ? round_q16(quo_q, div_ovf_q, 1'b0, LimR2) : 64'd0;
        default: begin
          sq_in_q  <= quo_q;
          se_sat_q <= div_ovf_q;
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // output register
  logic few;
  assign few = (n64 <= {62'd0, order_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      slope_o        <= slope_q[31:0];
      intercept_o    <= icpt_q[47:0];
      r_squared_o    <= r2_q[16:0];
      std_error_o    <= few ? 32'd0 : (se_sat_q ? 32'hFFFF_FFFF : sq_res_q[31:0]);
      sample_count_o <= count_q;
      if (few)          fit_status_o <= FIT_FEW;
      else if (!dxx_nz) fit_status_o <= FIT_ZERO_VX;
      else if (!dyy_nz) fit_status_o <= FIT_ZERO_VY;
      else              fit_status_o <= FIT_OK;
    end
  end

endmodule

// File: rtl/lsf_ctrl.sv
// ----------------------------------------------------------------------------
// lsf_ctrl
// Sequencer: sample intake, summing pass, fit steps and output handshake.
// ----------------------------------------------------------------------------
`include "least_squares_line_fit_macros.svh"

module lsf_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               last_sample_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output lsf_pkg::lsf_cmd_t  cmd_o,
  input  lsf_pkg::lsf_stat_t stat_i
);

  import lsf_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_PASS   = 3'd1;
  localparam logic [2:0] S_LAUNCH = 3'd2;
  localparam logic [2:0] S_WAIT   = 3'd3;
  localparam logic [2:0] S_LOAD   = 3'd4;

  logic [2:0]       state_q, state_d;
  logic [StepW-1:0] step_q, step_d;
  logic             out_valid_q, out_valid_d;
  logic             accept;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign accept      = in_valid_i && !in_stall_o;

  // next state and commands
  always_comb begin
    state_d          = state_q;
    step_d           = step_q;
    out_valid_d      = out_valid_q && out_stall_i;
    cmd_o.store      = 1'b0;
    cmd_o.pass_start = 1'b0;
    cmd_o.op_start   = 1'b0;
    cmd_o.load       = 1'b0;
    cmd_o.step       = step_q;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.store = accept;
        if (accept && last_sample_i) begin
          cmd_o.pass_start = 1'b1;
          state_d          = S_PASS;
        end
      end
      S_PASS: begin
        if (stat_i.pass_done) begin
          step_d  = STEP_N_SXX;
          state_d = S_LAUNCH;
        end
      end
      S_LAUNCH: begin
        cmd_o.op_start = 1'b1;
        state_d        = S_WAIT;
      end
      S_WAIT: begin
        if (stat_i.op_done) begin
          if (step_q == STEP_FINAL) begin
            state_d = S_LOAD;
          end else begin
            step_d  = step_q + StepW'(1);
            state_d = S_LAUNCH;
          end
        end
      end
      S_LOAD: begin
        // output register free or being emptied this cycle
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.load  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= STEP_N_SXX;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  `LSF_ASSERT_IMP(a_pass_done_in_pass, stat_i.pass_done, state_q == S_PASS, "pass done outside pass")
  `LSF_ASSERT_IMP(a_op_done_in_wait, stat_i.op_done, state_q == S_WAIT, "unit done while not waiting")
  `LSF_ASSERT_NXT(a_load_shows_word, cmd_o.load, out_valid_q && state_q == S_IDLE, "load lost word")

endmodule

// File: rtl/least_squares_line_fit.sv
// ----------------------------------------------------------------------------
// least_squares_line_fit
// Least-squares straight-line fit over a stored set of sample pairs.
// ----------------------------------------------------------------------------
// Usage:
//  Input channel (in_valid_i / in_stall_o) moves one sample word per cycle
//  while the block is idle; each word is written to the x and y sample RAMs.
//  A word with last_sample_i set is stored too and starts the fit; a word
//  arriving with the store full is dropped but its last flag still counts.
//  After the last word is taken, the fit makes a summing pass over the RAMs,
//  then twelve shift-add multiplies, four restoring divides and a square root
//  on shared serial units, each step with its launch and handoff, and at the
//  end loads the result word into the output register.
//  in_stall_o stays high during the fit.
//  The result word sits in an output register (out_valid_o / out_stall_i);
//  new samples are taken while it waits, and a following fit holds before
//  loading the output register until the receiver takes the previous word.
//  model_order is written through cfg_we_i / cfg_wdata_i; the user must do so
//  only while idle, as the block does not enforce it. Reset empties the store,
//  clears out_valid_o and sets model_order to 2; the RAMs need no clearing pass.
// ----------------------------------------------------------------------------
module least_squares_line_fit #(
  parameter int MAX_SAMPLES = lsf_pkg::DefMaxSamples,
  parameter int SAMPLE_BITS = lsf_pkg::DefSampleBits
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0]    sample_x_i,
  input  logic signed [SAMPLE_BITS-1:0]    sample_y_i,
  input  logic                             last_sample_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [31:0]               slope_o,
  output logic signed [47:0]               intercept_o,
  output logic [16:0]                      r_squared_o,
  output logic [31:0]                      std_error_o,
  output logic [$clog2(MAX_SAMPLES+1)-1:0] sample_count_o,
  output logic [1:0]                       fit_status_o,
  input  logic                             cfg_we_i,
  input  logic [1:0]                       cfg_wdata_i
);

  import lsf_pkg::*;

  lsf_cmd_t  cmd;
  lsf_stat_t stat;

  lsf_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .last_sample_i(last_sample_i),
    .in_stall_o   (in_stall_o),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .cmd_o        (cmd),
    .stat_i       (stat)
  );

  lsf_datapath #(
    .MAX_SAMPLES(MAX_SAMPLES),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .sample_x_i    (sample_x_i),
    .sample_y_i    (sample_y_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .slope_o       (slope_o),
    .intercept_o   (intercept_o),
    .r_squared_o   (r_squared_o),
    .std_error_o   (std_error_o),
    .sample_count_o(sample_count_o),
    .fit_status_o  (fit_status_o)
  );

endmodule
